### rtl/core/assert_macros.svh
// Concurrent assertion helpers; every user has clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cond never holds on a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/core/hcbd_pkg.sv
package hcbd_pkg;

	localparam int SIZE_BITS_DEF = 32;
	localparam int NAME_LEN      = 17;
	localparam int VALUE_LEN     = 8;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_SIZE    = 5'b00010,
		PH_PAYLOAD = 5'b00100,
		PH_SKIP    = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	// header line match state
	typedef struct packed {
		logic [4:0] name_pos;
		logic       name_ok;
		logic [3:0] val_pos;
		logic       val_ok;
		logic       colon;
	} match_t;

	localparam match_t MATCH_CLEAR = '{name_pos: 5'd0, name_ok: 1'b1,
		val_pos: 4'd0, val_ok: 1'b1, colon: 1'b0};

	typedef struct packed {
		logic [7:0] payload_byte;
		kind_t      kind;
		logic       was_chunked;
	} result_t;

	function automatic logic [7:0] name_char(input logic [4:0] pos);
		logic [7:0] c;
		case (pos)
			5'd0:    c = "T";
			5'd1:    c = "r";
			5'd2:    c = "a";
			5'd3:    c = "n";
			5'd4:    c = "s";
			5'd5:    c = "f";
			5'd6:    c = "e";
			5'd7:    c = "r";
			5'd8:    c = "-";
			5'd9:    c = "E";
			5'd10:   c = "n";
			5'd11:   c = "c";
			5'd12:   c = "o";
			5'd13:   c = "d";
			5'd14:   c = "i";
			5'd15:   c = "n";
			5'd16:   c = "g";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] value_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = " ";
			4'd1:    c = "c";
			4'd2:    c = "h";
			4'd3:    c = "u";
			4'd4:    c = "n";
			4'd5:    c = "k";
			4'd6:    c = "e";
			4'd7:    c = "d";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Advance the name or value match by one character.
	function automatic match_t feed(input match_t m, input logic [7:0] c);
		match_t r;
		r = m;
		if (!m.colon && c == CH_COLON) begin
			r.colon = 1'b1;
		end else if (!m.colon) begin
			if (m.name_ok && m.name_pos < 5'(NAME_LEN) && c == name_char(m.name_pos))
				r.name_pos = m.name_pos + 5'd1;
			else
				r.name_ok = 1'b0;
		end else begin
			if (m.val_ok && m.val_pos < 4'(VALUE_LEN) && c == value_char(m.val_pos))
				r.val_pos = m.val_pos + 4'd1;
			else
				r.val_ok = 1'b0;
		end
		return r;
	endfunction

	// {is_hex, digit}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		if (c >= "0" && c <= "9")
			r = {1'b1, 4'(c - "0")};
		else if (c >= "a" && c <= "f")
			r = {1'b1, 4'(c - "a" + 8'd10)};
		else if (c >= "A" && c <= "F")
			r = {1'b1, 4'(c - "A" + 8'd10)};
		else
			r = 5'd0;
		return r;
	endfunction

endpackage

### rtl/core/hcbd_hdr.sv
module hcbd_hdr (
	input  hcbd_pkg::match_t cur,
	input  logic             prev_cr,
	input  logic [7:0]       byte_in,
	output hcbd_pkg::match_t nxt
);
	import hcbd_pkg::*;

	match_t after_cr;

	// a CR not followed by LF counts as a plain line character
	always_comb begin
		after_cr = prev_cr ? feed(cur, CH_CR) : cur;
		nxt      = (byte_in == CH_CR) ? after_cr : feed(after_cr, byte_in);
	end

endmodule

### rtl/core/hcbd_ctl.sv
`include "assert_macros.svh"

module hcbd_ctl #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic              restart,
	output logic              res_valid,
	output hcbd_pkg::result_t res
);
	import hcbd_pkg::*;

	phase_t                 phase_q, cur_phase, n_phase;
	match_t                 match_q, cur_match, n_match, hdr_match;
	logic                   prev_cr_q, cur_prev_cr, n_prev_cr;
	logic                   chunked_q, cur_chunked, n_chunked;
	logic [SIZE_BITS-1:0]   size_q, cur_size, n_size, size_dec;
	logic                   hex_stop_q, cur_hex_stop, n_hex_stop;
	logic [1:0]             skip_q, cur_skip, n_skip;
	logic [4:0]             hex;

	always_comb begin
		if (restart) begin
			cur_phase    = PH_HEADER;
			cur_match    = MATCH_CLEAR;
			cur_prev_cr  = 1'b0;
			cur_chunked  = 1'b0;
			cur_size     = '0;
			cur_hex_stop = 1'b0;
			cur_skip     = 2'd0;
		end else begin
			cur_phase    = phase_q;
			cur_match    = match_q;
			cur_prev_cr  = prev_cr_q;
			cur_chunked  = chunked_q;
			cur_size     = size_q;
			cur_hex_stop = hex_stop_q;
			cur_skip     = skip_q;
		end
	end

	hcbd_hdr u_hdr (
		.cur     (cur_match),
		.prev_cr (cur_prev_cr),
		.byte_in (byte_in),
		.nxt     (hdr_match)
	);

	assign hex      = hex_digit(byte_in);
	assign size_dec = cur_size - SIZE_BITS'(1);

	always_comb begin
		n_phase         = cur_phase;
		n_match         = cur_match;
		n_prev_cr       = cur_prev_cr;
		n_chunked       = cur_chunked;
		n_size          = cur_size;
		n_hex_stop      = cur_hex_stop;
		n_skip          = cur_skip;
		res_valid       = 1'b0;
		res.payload_byte = 8'h00;
		res.kind        = KIND_DATA;
		res.was_chunked = cur_chunked;
		case (cur_phase)
			PH_HEADER: begin
				if (byte_in == CH_LF && cur_prev_cr) begin
					if (cur_match.name_ok && cur_match.name_pos == 5'd0) begin
						// empty name ends the headers
						if (cur_chunked) begin
							n_phase    = PH_SIZE;
							n_size     = '0;
							n_hex_stop = 1'b0;
							n_prev_cr  = 1'b0;
						end else begin
							n_phase   = PH_DONE;
							res_valid = 1'b1;
							res.kind  = KIND_END;
						end
					end else begin
						if (cur_match.colon && cur_match.name_ok &&
						    cur_match.name_pos == 5'(NAME_LEN) && cur_match.val_ok &&
						    cur_match.val_pos == 4'(VALUE_LEN))
							n_chunked = 1'b1;
						n_match   = MATCH_CLEAR;
						n_prev_cr = 1'b0;
					end
				end else begin
					n_match   = hdr_match;
					n_prev_cr = (byte_in == CH_CR);
				end
			end
			PH_SIZE: begin
				if (byte_in == CH_LF && cur_prev_cr) begin
					if (cur_size == '0) begin
						n_phase   = PH_DONE;
						res_valid = 1'b1;
						res.kind  = KIND_END;
					end else begin
						n_phase = PH_PAYLOAD;
					end
				end else begin
					n_prev_cr = (byte_in == CH_CR);
					if (!cur_hex_stop) begin
						if (!hex[4]) begin
							n_hex_stop = 1'b1;
						end else if (cur_size[SIZE_BITS-1 -: 4] != 4'd0) begin
							// next digit would overflow the size
							n_phase   = PH_DONE;
							res_valid = 1'b1;
							res.kind  = KIND_ERR;
						end else begin
							n_size = {cur_size[SIZE_BITS-5:0], hex[3:0]};
						end
					end
				end
			end
			PH_PAYLOAD: begin
				n_size           = size_dec;
				res_valid        = 1'b1;
				res.payload_byte = byte_in;
				if (size_dec == '0) begin
					n_phase = PH_SKIP;
					n_skip  = 2'd2;
				end
			end
			PH_SKIP: begin
				n_skip = (cur_skip != 2'd0) ? cur_skip - 2'd1 : cur_skip;
				if (n_skip == 2'd0) begin
					n_phase    = PH_SIZE;
					n_size     = '0;
					n_hex_stop = 1'b0;
					n_prev_cr  = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			match_q    <= MATCH_CLEAR;
			prev_cr_q  <= 1'b0;
			chunked_q  <= 1'b0;
			size_q     <= '0;
			hex_stop_q <= 1'b0;
			skip_q     <= 2'd0;
		end else if (step) begin
			phase_q    <= n_phase;
			match_q    <= n_match;
			prev_cr_q  <= n_prev_cr;
			chunked_q  <= n_chunked;
			size_q     <= n_size;
			hex_stop_q <= n_hex_stop;
			skip_q     <= n_skip;
		end
	end

	`ASSERT_CLK(a_payload_nonzero, phase_q == PH_PAYLOAD |-> size_q != '0, "payload with zero count")
	`ASSERT_CLK(a_skip_nonzero, phase_q == PH_SKIP |-> skip_q != 2'd0, "skip phase with zero count")

endmodule

### rtl/core/http_chunked_body_decoder_unit.sv
// An accepted item passes through the input register, then the result register,
// which holds its result, if any.
// Throughput: one byte per cycle while out_ready does not stall; the byte parser is one combinational pass.
// Reset: arst_n clears the parser to the header line start and empties both registers.
`include "assert_macros.svh"

module http_chunked_body_decoder_unit #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic [1:0] kind,
	output logic       was_chunked
);
	import hcbd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;
	logic       advance;
	logic       step;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	// the input register moves on whenever the result register has room
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1    <= byte_in;
			restart_s1 <= restart;
		end
	end

	hcbd_ctl #(
		.SIZE_BITS (SIZE_BITS)
	) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.restart   (restart_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_q.payload_byte;
	assign kind         = out_q.kind;
	assign was_chunked  = out_q.was_chunked;

	`ASSERT_CLK(a_data_needs_chunked, out_valid_q && out_q.kind == KIND_DATA |-> out_q.was_chunked, "payload item outside a chunked body")
	`ASSERT_CLK(a_s1_holds, valid_s1 && !advance |=> valid_s1 && $stable(byte_s1), "input stage lost a stalled item")
	`ASSERT_NEVER(a_full_in_ready, valid_s1 && out_valid_q && !out_ready && in_ready, "input taken with both stages blocked")

endmodule

### tb/http_chunked_body_decoder_unit_test.sv
module http_chunked_body_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hcbd_pkg::*;

	localparam int SIZE_W         = SIZE_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 6;

	localparam logic [8*NAME_LEN-1:0]  TE_NAME  = "Transfer-Encoding";
	localparam logic [8*VALUE_LEN-1:0] TE_VALUE = " chunked";

	typedef struct {
		logic [7:0] data;
		logic       restart;
	} byte_item_t;

	typedef enum int {
		FLOW_FREE,
		FLOW_SEND_IDLE,
		FLOW_RECV_STALL,
		FLOW_BOTH,
		FLOW_HOLD
	} flow_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] byte_in = 8'h00;
	logic       restart = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] payload_byte;
	logic [1:0] kind;
	logic       was_chunked;

	http_chunked_body_decoder_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_in      (byte_in),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.kind         (kind),
		.was_chunked  (was_chunked)
	);

	byte_item_t pending_bytes[$];
	result_t    expected_results[$];
	byte_item_t next_item;
	result_t    oldest;
	bit         restart_next = 1'b0;
	int         queued_total = 0;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	int         hold_count = 0;
	int         send_idle = 0;
	int         recv_stall = 0;
	flow_t      flow = FLOW_FREE;

	// decoder state mirrored from the byte stream
	phase_t            dec_phase;
	logic [4:0]        name_pos;
	logic              name_ok;
	logic [3:0]        value_pos;
	logic              value_ok;
	logic              colon_seen;
	logic              prev_cr;
	logic              chunked_seen;
	logic [SIZE_W-1:0] chunk_left;
	logic              digits_done;
	logic [1:0]        skip_left;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic clear_line();
		name_pos = '0;
		name_ok = 1'b1;
		value_pos = '0;
		value_ok = 1'b1;
		colon_seen = 1'b0;
		prev_cr = 1'b0;
	endtask

	task automatic reset_decoder();
		dec_phase = PH_HEADER;
		clear_line();
		chunked_seen = 1'b0;
		chunk_left = '0;
		digits_done = 1'b0;
		skip_left = '0;
	endtask

	task automatic open_size_line();
		chunk_left = '0;
		digits_done = 1'b0;
		prev_cr = 1'b0;
		dec_phase = PH_SIZE;
	endtask

	task automatic expect_result(input logic [7:0] data, input kind_t k);
		result_t r;
		r.payload_byte = data;
		r.kind = k;
		r.was_chunked = chunked_seen;
		expected_results.push_back(r);
	endtask

	// Everything before the first colon is name, the rest is value.
	task automatic match_header_char(input logic [7:0] c);
		if (!colon_seen && c == CH_COLON) begin
			colon_seen = 1'b1;
		end else if (!colon_seen) begin
			if (name_ok && name_pos < NAME_LEN &&
					c == TE_NAME[8*(NAME_LEN-1-name_pos) +: 8])
				name_pos = name_pos + 5'd1;
			else
				name_ok = 1'b0;
		end else begin
			if (value_ok && value_pos < VALUE_LEN &&
					c == TE_VALUE[8*(VALUE_LEN-1-value_pos) +: 8])
				value_pos = value_pos + 4'd1;
			else
				value_ok = 1'b0;
		end
	endtask

	function automatic int hex_of(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0");
		if (c >= "a" && c <= "f")
			return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic rs);
		int d;
		if (rs)
			reset_decoder();
		case (dec_phase)
			PH_HEADER: begin
				if (b == CH_LF && prev_cr) begin
					if (name_ok && name_pos == 0) begin
						if (chunked_seen) begin
							open_size_line();
						end else begin
							dec_phase = PH_DONE;
							expect_result(8'h00, KIND_END);
						end
					end else begin
						if (colon_seen && name_ok && name_pos == NAME_LEN &&
								value_ok && value_pos == VALUE_LEN)
							chunked_seen = 1'b1;
						clear_line();
					end
				end else begin
					// a CR not followed by LF is part of the line
					if (prev_cr)
						match_header_char(CH_CR);
					if (b == CH_CR) begin
						prev_cr = 1'b1;
					end else begin
						prev_cr = 1'b0;
						match_header_char(b);
					end
				end
			end
			PH_SIZE: begin
				if (b == CH_LF && prev_cr) begin
					if (chunk_left == 0) begin
						dec_phase = PH_DONE;
						expect_result(8'h00, KIND_END);
					end else begin
						dec_phase = PH_PAYLOAD;
					end
				end else begin
					prev_cr = (b == CH_CR);
					if (!digits_done) begin
						d = hex_of(b);
						if (d < 0) begin
							digits_done = 1'b1;
						end else if (chunk_left[SIZE_W-1 -: 4] != 0) begin
							dec_phase = PH_DONE;
							expect_result(8'h00, KIND_ERR);
						end else begin
							chunk_left = {chunk_left[SIZE_W-5:0], 4'(d)};
						end
					end
				end
			end
			PH_PAYLOAD: begin
				chunk_left = chunk_left - SIZE_W'(1);
				if (chunk_left == 0) begin
					dec_phase = PH_SKIP;
					skip_left = 2'd2;
				end
				expect_result(b, KIND_DATA);
			end
			PH_SKIP: begin
				if (skip_left != 0)
					skip_left = skip_left - 2'd1;
				if (skip_left == 0)
					open_size_line();
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, field, want, got);
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		byte_item_t it;
		it.data = b;
		it.restart = restart_next;
		restart_next = 1'b0;
		pending_bytes.push_back(it);
		queued_total++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_line(input string s);
		push_text(s);
		push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic push_hex(input logic [35:0] value, input bit upper, input int pad);
		logic [3:0] digits[$];
		repeat (pad)
			push_byte("0");
		do begin
			digits.push_front(value[3:0]);
			value = value >> 4;
		end while (value != 0);
		// map nibble to ASCII, letters in the chosen case
		foreach (digits[i])
			push_byte(digits[i] < 4'd10 ? 8'h30 + 8'(digits[i]) :
				(upper ? 8'h37 : 8'h57) + 8'(digits[i]));
	endtask

	task automatic add_extension();
		case ($urandom_range(3))
			0: push_text(";name=val");
			1: push_text(" ;q");
			default: begin
			end
		endcase
	endtask

	task automatic add_other_header();
		case ($urandom_range(11))
			0: push_line("Host: example");
			1: push_line("Content-Type: text/html");
			2: push_line("Transfer-encoding: chunked");
			3: push_line("Transfer-Encoding: gzip");
			4: push_line("Transfer-Encoding:chunked");
			5: push_line("Transfer-Encoding: chunked ");
			6: push_line("Transfer-Encodings: chunked");
			7: push_line("Transfer-Encoding chunked");
			8: push_line("Transfer-Encoding: chun\015ked");
			9: push_line(": chunked");
			10: push_line("Transfer-Encoding: Chunked");
			default: begin
				repeat ($urandom_range(8))
					push_byte(8'($urandom));
				push_line("");
			end
		endcase
	endtask

	task automatic add_response();
		bit chunked;
		int n_hdr;
		int te_at;
		int chunk_len;
		restart_next = 1'b1;
		push_line($urandom_range(1) ? "HTTP/1.1 200 OK" : "HTTP/1.0 404 Not Found");
		chunked = ($urandom_range(3) != 0);
		n_hdr = $urandom_range(3);
		te_at = $urandom_range(n_hdr);
		for (int i = 0; i <= n_hdr; i++) begin
			if (chunked && i == te_at)
				push_line("Transfer-Encoding: chunked");
			if (i < n_hdr)
				add_other_header();
		end
		push_line("");
		if (!chunked) begin
			repeat ($urandom_range(4))
				push_byte(8'($urandom));
			return;
		end
		repeat ($urandom_range(3)) begin
			chunk_len = ($urandom_range(15) == 0) ? $urandom_range(300, 17) :
				$urandom_range(12, 1);
			push_hex(36'(chunk_len), 1'($urandom_range(1)), $urandom_range(2));
			add_extension();
			push_line("");
			for (int i = 0; i < chunk_len; i++) begin
				// drop the rest of the response now and then
				if ($urandom_range(199) == 0)
					return;
				push_byte(8'($urandom));
			end
			if ($urandom_range(7) == 0) begin
				push_byte(8'($urandom));
				push_byte(8'($urandom));
			end else begin
				push_line("");
			end
		end
		case ($urandom_range(15))
			0: push_hex({4'h1, 32'($urandom)}, 1'($urandom_range(1)), $urandom_range(2));
			1: push_hex(36'hf_ffff_ffff, 1'($urandom_range(1)), 0);
			default: begin
				push_hex(36'd0, 1'b0, $urandom_range(2));
				add_extension();
				push_line("");
				if ($urandom_range(1))
					push_line("Trailer: x");
			end
		endcase
		push_line("");
		repeat ($urandom_range(3))
			push_byte(8'($urandom));
	endtask

	task automatic add_noise();
		repeat ($urandom_range(20, 3)) begin
			restart_next = ($urandom_range(7) == 0);
			push_byte(8'($urandom));
		end
	endtask

	task automatic add_directed();
		// empty header block without restart, then a byte after the end
		push_line("");
		push_byte("x");
		restart_next = 1'b1;
		push_line("Transfer-Encoding: chunked");
		push_line("");
		push_line("2;a=b");
		push_byte(8'h00);
		push_byte(8'hff);
		push_line("");
		push_line("0");
		// no colon, then a lone CR inside a line
		restart_next = 1'b1;
		push_line("Transfer-Encoding chunked");
		push_line("A\015B: c");
		push_line("");
		restart_next = 1'b1;
		push_line("Transfer-Encoding: chunked");
		push_line("");
		push_text("fffffffff");
		// largest size that fits, cut short by restart
		restart_next = 1'b1;
		push_line("Transfer-Encoding: chunked");
		push_line("");
		push_line("FFFFFFFF");
		push_text("ab");
		restart_next = 1'b1;
		push_line(": x");
		push_line("");
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random(input flow_t f, input int idle_pct, input int stall_pct,
			input int n_items);
		int start_count;
		@(negedge clk);
		flow = f;
		send_idle = idle_pct;
		recv_stall = stall_pct;
		start_count = queued_total;
		while (queued_total - start_count < n_items) begin
			if ($urandom_range(9) < 8)
				add_response();
			else
				add_noise();
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
				next_item = pending_bytes.pop_front();
				in_valid <= 1'b1;
				byte_in <= next_item.data;
				restart <= next_item.restart;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (flow == FLOW_HOLD && hold_count < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				decode_byte(byte_in, restart);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got byte %h kind %0d chunked %b",
						$time, payload_byte, kind, was_chunked);
				end else begin
					oldest = expected_results.pop_front();
					check_field("payload_byte", oldest.payload_byte, payload_byte);
					check_field("kind", 8'(oldest.kind), 8'(kind));
					check_field("was_chunked", 8'(oldest.was_chunked), 8'(was_chunked));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("[http_chunked_body_decoder_unit] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		reset_decoder();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		add_directed();
		wait_drained();
		run_random(FLOW_FREE, 0, 0, 300);
		run_random(FLOW_HOLD, 0, 0, 300);
		run_random(FLOW_SEND_IDLE, 88, 0, 300);
		run_random(FLOW_RECV_STALL, 0, 88, 300);
		run_random(FLOW_BOTH, 11, 11, 300);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[http_chunked_body_decoder_unit] OK");
		else
			$display("[http_chunked_body_decoder_unit] ERROR");
		$finish;
	end

endmodule
